FILE: design/nlpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Next-line prefetch queue package
// Shared constants, operation and register codes, and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package nlpq_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_LINE_BYTES  = 64;
  localparam int DEF_MAX_LINES   = 8;
  localparam int DEF_ADDR_BITS   = 48;

  localparam int OP_W       = 2;
  localparam int TID_W      = 3;
  localparam int CNT_OUT_W  = 5;
  localparam int DIST_W     = 4;
  localparam int LCNT_W     = 4;
  localparam int MAXP_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [OP_W-1:0] OP_OBSERVE = 2'd0;
  localparam logic [OP_W-1:0] OP_POP     = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PENDING = 2'd3;

  localparam logic              RST_ENABLE      = 1'b0;
  localparam logic [DIST_W-1:0] RST_DISTANCE    = 4'd1;
  localparam logic [LCNT_W-1:0] RST_COUNT       = 4'd1;
  localparam logic [MAXP_W-1:0] RST_MAX_PENDING = 5'd16;

  typedef struct packed {
    logic accept;
    logic obs_step;
    logic flush_step;
    logic resp_load;
  } nlpq_cmd_t;

  typedef struct packed {
    logic start_obs;
    logic start_flush;
    logic last_step;
    logic queue_full;
  } nlpq_stat_t;

endpackage
`default_nettype wire

FILE: design/nlpq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Next-line prefetch queue controller
// Sequences each item: accept, per-line or per-entry steps, then the
// result hand-off into the output register.
// ----------------------------------------------------------------------------
module nlpq_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  wire                 out_tready,
  input  nlpq_pkg::nlpq_stat_t stat,
  output nlpq_pkg::nlpq_cmd_t  cmd
);
  import nlpq_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_OBS   = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    cmd.accept     = in_tvalid && in_tready;
    cmd.obs_step   = (state_r == S_OBS);
    cmd.flush_step = (state_r == S_FLUSH);
    cmd.resp_load  = (state_r == S_RESP) && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.accept) begin
          if (stat.start_obs) state_nxt = S_OBS;
          else if (stat.start_flush) state_nxt = S_FLUSH;
          else state_nxt = S_RESP;
        end
      end
      S_OBS: begin
        if (stat.last_step) state_nxt = S_RESP;
      end
      S_FLUSH: begin
        if (stat.last_step) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.resp_load) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: design/nlpq_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Next-line prefetch queue datapath
// Configuration registers, the ordered shift queue of line targets, the
// duplicate compare, the step counter and the result register.
// ----------------------------------------------------------------------------
module nlpq_dp #(
  parameter int QUEUE_DEPTH = nlpq_pkg::DEF_QUEUE_DEPTH,
  parameter int LINE_BYTES  = nlpq_pkg::DEF_LINE_BYTES,
  parameter int MAX_LINES   = nlpq_pkg::DEF_MAX_LINES,
  parameter int ADDR_BITS   = nlpq_pkg::DEF_ADDR_BITS,
  parameter int IN_W        = ((nlpq_pkg::OP_W + ADDR_BITS + nlpq_pkg::TID_W + 7) / 8) * 8,
  parameter int OUT_W       = ((1 + ADDR_BITS + nlpq_pkg::TID_W + nlpq_pkg::CNT_OUT_W + 7)
                               / 8) * 8
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire [IN_W-1:0]                     in_tdata,
  output logic [OUT_W-1:0]                   out_tdata,
  input  wire                                cfg_we,
  input  wire [nlpq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [nlpq_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  nlpq_pkg::nlpq_cmd_t                cmd,
  output nlpq_pkg::nlpq_stat_t               stat
);
  import nlpq_pkg::*;

  localparam int OFF_W   = $clog2(LINE_BYTES);
  localparam int LINE_W  = ADDR_BITS - OFF_W;
  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int OCC_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int LINES_W = $clog2(MAX_LINES + 1);
  localparam int ITER_W  = (OCC_W > LINES_W) ? OCC_W : LINES_W;
  localparam int LCW     = (LCNT_W > LINES_W) ? LCNT_W : LINES_W;
  localparam int LIM_W   = ((MAXP_W > OCC_W) ? MAXP_W : OCC_W) + 1;

  // Configuration registers.
  logic              enable_r;
  logic [DIST_W-1:0] dist_r;
  logic [LCNT_W-1:0] lcount_r;
  logic [MAXP_W-1:0] maxp_r;

  // Queue: entry 0 is the oldest.
  logic [LINE_W-1:0] line_r   [QUEUE_DEPTH];
  logic [LINE_W-1:0] line_nxt [QUEUE_DEPTH];
  logic [TID_W-1:0]  thr_r    [QUEUE_DEPTH];
  logic [TID_W-1:0]  thr_nxt  [QUEUE_DEPTH];
  logic [OCC_W-1:0]  occ_r, occ_nxt;

  // Item context.
  logic [OP_W-1:0]   op_r;
  logic [TID_W-1:0]  tid_r;
  logic [LINE_W-1:0] tgt_r;
  logic [ITER_W-1:0] left_r;

  // Result register.
  logic                 res_tv_r;
  logic [ADDR_BITS-1:0] res_addr_r;
  logic [TID_W-1:0]     res_thr_r;
  logic [CNT_OUT_W-1:0] res_cnt_r;

  logic [OP_W-1:0]      in_op;
  logic [ADDR_BITS-1:0] in_addr;
  logic [TID_W-1:0]     in_tid;
  logic [ITER_W-1:0]    n_eff;
  logic [LIM_W-1:0]     limit;
  logic [LIM_W-1:0]     occ_inc;
  logic                 drop_after;
  logic [QUEUE_DEPTH-1:0] hit_vec;
  logic                 hit;
  logic                 keep;
  logic                 pop_hit;
  logic                 do_shift;
  logic                 do_write;
  logic [IDX_W-1:0]     wr_idx;
  logic [LINE_W-1:0]    wr_line;
  logic [TID_W-1:0]     wr_thr;

  assign in_op   = in_tdata[OP_W-1:0];
  assign in_addr = in_tdata[OP_W +: ADDR_BITS];
  assign in_tid  = in_tdata[OP_W + ADDR_BITS +: TID_W];

  always_comb begin
    if (LCW'(lcount_r) > LCW'(MAX_LINES)) n_eff = ITER_W'(MAX_LINES);
    else n_eff = ITER_W'(lcount_r);
    if (LIM_W'(maxp_r) > LIM_W'(QUEUE_DEPTH)) limit = LIM_W'(QUEUE_DEPTH);
    else limit = LIM_W'(maxp_r);
  end

  // The drop after an append fires once the new occupancy reaches the limit,
  // so the queue never holds more than QUEUE_DEPTH-1 entries between items.
  assign occ_inc    = LIM_W'(occ_r) + 1'b1;
  assign drop_after = (occ_inc >= limit);

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      hit_vec[i] = (OCC_W'(i) < occ_r) && (line_r[i] == tgt_r);
    end
  end

  assign hit     = |hit_vec;
  assign keep    = (thr_r[0] != tid_r);
  assign pop_hit = (op_r == OP_POP) && (occ_r != '0);

  always_comb begin
    stat.start_obs   = (in_op == OP_OBSERVE) && enable_r && (n_eff != '0);
    stat.start_flush = (in_op == OP_FLUSH) && (occ_r != '0);
    stat.last_step   = (left_r == ITER_W'(1));
    stat.queue_full  = (LIM_W'(occ_r) >= LIM_W'(QUEUE_DEPTH));
  end

  // Queue update: an optional shift toward the head, then at most one write.
  always_comb begin
    do_shift = 1'b0;
    do_write = 1'b0;
    wr_idx   = occ_r[IDX_W-1:0];
    wr_line  = tgt_r;
    wr_thr   = tid_r;
    occ_nxt  = occ_r;
    if (cmd.obs_step && !hit) begin
      if (drop_after) begin
        // Append then drop the oldest; with an empty queue nothing stays.
        if (occ_r != '0) begin
          do_shift = 1'b1;
          do_write = 1'b1;
          wr_idx   = IDX_W'(occ_r - 1'b1);
        end
      end else begin
        do_write = 1'b1;
        occ_nxt  = occ_r + 1'b1;
      end
    end else if (cmd.flush_step) begin
      // Rotate the head to the tail when it survives the flush.
      do_shift = 1'b1;
      do_write = keep;
      wr_idx   = IDX_W'(occ_r - 1'b1);
      wr_line  = line_r[0];
      wr_thr   = thr_r[0];
      if (!keep) occ_nxt = occ_r - 1'b1;
    end else if (cmd.resp_load && pop_hit) begin
      do_shift = 1'b1;
      occ_nxt  = occ_r - 1'b1;
    end
  end

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      line_nxt[i] = line_r[i];
      thr_nxt[i]  = thr_r[i];
    end
    if (do_shift) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        line_nxt[i] = line_r[i + 1];
        thr_nxt[i]  = thr_r[i + 1];
      end
    end
    if (do_write) begin
      line_nxt[wr_idx] = wr_line;
      thr_nxt[wr_idx]  = wr_thr;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      line_r[i] <= line_nxt[i];
      thr_r[i]  <= thr_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r    <= '0;
      enable_r <= RST_ENABLE;
      dist_r   <= RST_DISTANCE;
      lcount_r <= RST_COUNT;
      maxp_r   <= RST_MAX_PENDING;
    end else begin
      occ_r <= occ_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ENABLE:      enable_r <= cfg_data[0];
          CFG_DISTANCE:    dist_r   <= cfg_data[DIST_W-1:0];
          CFG_COUNT:       lcount_r <= cfg_data[LCNT_W-1:0];
          CFG_MAX_PENDING: maxp_r   <= cfg_data[MAXP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Item context and the step counter.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_op;
      tid_r <= in_tid;
      tgt_r <= in_addr[ADDR_BITS-1:OFF_W] + LINE_W'(dist_r);
      if (stat.start_obs) left_r <= n_eff;
      else left_r <= ITER_W'(occ_r);
    end else if (cmd.obs_step || cmd.flush_step) begin
      tgt_r  <= tgt_r + 1'b1;
      left_r <= left_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp_load) begin
      res_tv_r   <= pop_hit;
      res_addr_r <= pop_hit ? {line_r[0], OFF_W'(0)} : '0;
      res_thr_r  <= pop_hit ? thr_r[0] : '0;
      res_cnt_r  <= CNT_OUT_W'(occ_nxt);
    end
  end

  assign out_tdata = OUT_W'({res_cnt_r, res_thr_r, res_addr_r, res_tv_r});

endmodule
`default_nettype wire

FILE: design/next_line_prefetch_queue_core.sv
// A pop, a flush of an empty queue, an observe while disabled or with a line count of zero,
// or an unknown operation goes from acceptance straight to the result hand-off; an observe
// first makes one duplicate compare per generated line and a flush rotates one queue entry
// per cycle. One item is in work at a time; the next is accepted once the result has been
// loaded into the output register, which waits while out_tready is low and the output is full.
// Reset (synchronous, rst_n low) empties the queue and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Next-line prefetch queue core
// Keeps an ordered queue of next-line prefetch targets, fed by fetch
// observations and drained by pop and per-thread flush items.
// ----------------------------------------------------------------------------
module next_line_prefetch_queue_core #(
  parameter int QUEUE_DEPTH = nlpq_pkg::DEF_QUEUE_DEPTH,
  parameter int LINE_BYTES  = nlpq_pkg::DEF_LINE_BYTES,
  parameter int MAX_LINES   = nlpq_pkg::DEF_MAX_LINES,
  parameter int ADDR_BITS   = nlpq_pkg::DEF_ADDR_BITS,
  parameter int IN_W        = ((nlpq_pkg::OP_W + ADDR_BITS + nlpq_pkg::TID_W + 7) / 8) * 8,
  parameter int OUT_W       = ((1 + ADDR_BITS + nlpq_pkg::TID_W + nlpq_pkg::CNT_OUT_W + 7)
                               / 8) * 8
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_tvalid,
  output logic                           in_tready,
  // operation, fetch_address, thread_id (from bit 0 up), zero padded
  input  wire [IN_W-1:0]                 in_tdata,
  output logic                           out_tvalid,
  input  wire                            out_tready,
  // target_valid, target_address, target_thread, pending_count (from bit 0 up)
  output logic [OUT_W-1:0]               out_tdata,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire [nlpq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [nlpq_pkg::CFG_DATA_W-1:0] cfg_data
);
  import nlpq_pkg::*;

  nlpq_cmd_t  cmd;
  nlpq_stat_t stat;

  assign cfg_ready = 1'b1;

  nlpq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  nlpq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .LINE_BYTES  (LINE_BYTES),
    .MAX_LINES   (MAX_LINES),
    .ADDR_BITS   (ADDR_BITS),
    .IN_W        (IN_W),
    .OUT_W       (OUT_W)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

  // The limit rule keeps the queue below its full storage depth.
  assert property (@(posedge clk) disable iff (!rst_n) !stat.queue_full)
    else $error("queue occupancy reached storage depth");

  // At most one datapath action per cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept, cmd.obs_step, cmd.flush_step, cmd.resp_load}))
    else $error("overlapping datapath commands");

  // After an item is taken the block stays busy until its result is loaded.
  assert property (@(posedge clk) disable iff (!rst_n) cmd.accept |=> !in_tready)
    else $error("input accepted again while an item is in work");

  // Loading a result always presents it on the output channel.
  assert property (@(posedge clk) disable iff (!rst_n) cmd.resp_load |=> out_tvalid)
    else $error("result loaded but not presented");

endmodule
`default_nettype wire
